// ===== rtl/lrvt_pkg.sv =====
// ----------------------------------------------------------------------------
// LED ring visual timer package
// Shared types, constants and helper functions of the LED ring timer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrvt_pkg;

   localparam int NUM_RING_LEDS_DEFAULT = 12;
   localparam int FADE_LEVELS_DEFAULT   = 8;

   localparam int LED_W    = 4;
   localparam int LEVEL_W  = 4;
   localparam int BRIGHT_W = 8;
   localparam int CFG_W    = 24;
   localparam int TICK_W   = 32;
   localparam int SCALE_W  = LED_W + 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [BRIGHT_W-1:0] BRIGHT_STEP = 8'd8;
   localparam logic [BRIGHT_W-1:0] BRIGHT_MAX  = 8'd248;
   localparam logic [BRIGHT_W-1:0] COUNT_BRIGHT_RESET = 8'd48;
   localparam logic [BRIGHT_W-1:0] ALERT_BRIGHT_RESET = 8'd96;

   localparam logic [CFG_W-1:0] TICKS_PER_LEVEL_RESET = 24'd625;
   localparam logic [CFG_W-1:0] FLASH_TICKS_RESET     = 24'd1000;
   localparam logic [CFG_W-1:0] TIMEOUT_TICKS_RESET   = 24'd60000;

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_TICKS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS   = 2'd2;

   typedef enum logic [2:0] {
      MODE_IDLE        = 3'd0,
      MODE_COUNTDOWN   = 3'd1,
      MODE_ALERT       = 3'd2,
      MODE_COUNTUP     = 3'd3,
      MODE_EDIT_COUNT  = 3'd4,
      MODE_EDIT_ALERT  = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_ADDED   = 3'd1,
      EV_RESET   = 3'd2,
      EV_FADE    = 3'd3,
      EV_FLASH   = 3'd4,
      EV_EXPIRED = 3'd5,
      EV_BRIGHT  = 3'd6,
      EV_SAVED   = 3'd7
   } event_type;

   typedef enum logic [1:0] {
      CS_WAIT  = 2'd0,
      CS_EXEC  = 2'd1,
      CS_SCALE = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic scale;
   } ctrl_cmd_type;

   typedef struct packed {
      logic run_start;
   } dp_status_type;

   function automatic logic [BRIGHT_W-1:0] bright_step(input logic [BRIGHT_W-1:0] b,
                                                      input logic up);
      logic [BRIGHT_W:0] sum;
      sum = {1'b0, b} + {1'b0, BRIGHT_STEP};
      if (up) begin
         bright_step = (sum > {1'b0, BRIGHT_MAX}) ? BRIGHT_MAX : sum[BRIGHT_W-1:0];
      end else begin
         bright_step = (b >= BRIGHT_STEP) ? (b - BRIGHT_STEP) : '0;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lrvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// LED ring timer controller
// Sequences request capture, state update and run length scaling, and owns
// the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lrvt_ctrl
   import lrvt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_WAIT: begin
            if (req_valid) begin
               state_in = CS_EXEC;
            end
         end
         CS_EXEC: begin
            if (out_free) begin
               state_in = status.run_start ? CS_SCALE : CS_WAIT;
            end
         end
         CS_SCALE: begin
            state_in = CS_WAIT;
         end
         default: begin
            state_in = CS_WAIT;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         CS_WAIT: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         CS_EXEC: begin
            cmd.exec = out_free;
         end
         CS_SCALE: begin
            cmd.scale = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/lrvt_datapath.sv =====
// ----------------------------------------------------------------------------
// LED ring timer datapath
// Holds the timer state, the settings registers and the response register,
// and computes one tick of the six-mode timer.
// ----------------------------------------------------------------------------
`default_nettype none

module lrvt_datapath
   import lrvt_pkg::*;
#(
   parameter int NUM_RING_LEDS = NUM_RING_LEDS_DEFAULT,
   parameter int FADE_LEVELS   = FADE_LEVELS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctrl_cmd_type         cmd,
   output dp_status_type             status,
   input  wire logic                 req_btn_start,
   input  wire logic                 req_btn_add,
   input  wire logic                 req_long_press_add,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data,
   output logic [2:0]                rsp_timer_mode,
   output logic [LED_W-1:0]          rsp_active_led,
   output logic [BRIGHT_W-1:0]       rsp_shade_value,
   output logic [BRIGHT_W-1:0]       rsp_full_value,
   output logic                      rsp_flash_phase,
   output logic [2:0]                rsp_event_code
);

   localparam logic [LED_W-1:0]    NUM_LEDS   = LED_W'(NUM_RING_LEDS);
   localparam logic [LEVEL_W-1:0]  LEVEL_TOP  = LEVEL_W'(FADE_LEVELS);
   localparam logic [BRIGHT_W-1:0] UNIT_RESET = BRIGHT_W'(COUNT_BRIGHT_RESET / FADE_LEVELS);

   logic [CFG_W-1:0] tpl_ff, flash_ticks_ff, timeout_ff;

   logic btn_start_ff, btn_add_ff, long_press_ff;

   mode_type             mode_ff, mode_nx;
   logic [LED_W-1:0]     led_ff, led_nx;
   logic [LEVEL_W-1:0]   level_ff, level_nx;
   logic [TICK_W-1:0]    tick_ff, tick_nx, tick_inc;
   logic [TICK_W-1:0]    total_ff;
   logic [CFG_W-1:0]     phase_ff, phase_nx, phase_step, phase_inc;
   logic                 flash_ff, flash_nx;
   logic [BRIGHT_W-1:0]  count_ff, count_nx;
   logic [BRIGHT_W-1:0]  alert_ff, alert_nx;
   logic [BRIGHT_W-1:0]  saved_ff, saved_nx;
   logic [BRIGHT_W-1:0]  unit_ff;
   logic [SCALE_W-1:0]   scale_ff, scale_nx;
   logic [CFG_W-1:0]     period;
   logic [LED_W-1:0]     run_leds;
   logic [LEVEL_W-1:0]   level_dec, fade_level;
   logic [BRIGHT_W-1:0]  fade_shade, shade;
   logic [BRIGHT_W-1:0]  full;
   logic [LED_W-1:0]     active;
   event_type            ev;
   logic                 st, ad, lp, both;

   assign st   = btn_start_ff;
   assign ad   = btn_add_ff;
   assign lp   = long_press_ff;
   assign both = st && ad;

   assign status.run_start = st && !ad &&
                             (mode_ff == MODE_IDLE || mode_ff == MODE_ALERT);

   assign period     = (tpl_ff == '0) ? CFG_W'(1) : tpl_ff;
   assign tick_inc   = (mode_ff != MODE_IDLE && tick_ff != '1) ? (tick_ff + 1'b1) : tick_ff;
   assign phase_inc  = phase_ff + 1'b1;
   assign phase_step = (phase_inc == period) ? '0 : phase_inc;
   assign level_dec  = level_ff - 1'b1;
   assign fade_level = (mode_ff == MODE_COUNTUP) ? (LEVEL_TOP - level_dec) : level_dec;
   assign fade_shade = BRIGHT_W'(fade_level) * unit_ff;

   always_comb begin
      mode_nx  = mode_ff;
      led_nx   = led_ff;
      level_nx = level_ff;
      tick_nx  = tick_inc;
      phase_nx = phase_step;
      flash_nx = flash_ff;
      count_nx = count_ff;
      alert_nx = alert_ff;
      saved_nx = saved_ff;
      run_leds = NUM_LEDS;
      ev       = EV_NONE;
      shade    = '0;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (both) begin
               led_nx = '0;
               ev     = EV_RESET;
            end else if (ad) begin
               if (led_ff < NUM_LEDS) begin
                  led_nx = led_ff + 1'b1;
                  ev     = EV_ADDED;
               end else begin
                  led_nx = '0;
                  ev     = EV_RESET;
               end
            end else if (st) begin
               tick_nx  = '0;
               phase_nx = '0;
               level_nx = LEVEL_TOP;
               if (led_ff != '0) begin
                  run_leds = led_ff;
                  led_nx   = led_ff - 1'b1;
                  mode_nx  = MODE_COUNTDOWN;
               end else begin
                  led_nx  = '0;
                  mode_nx = MODE_COUNTUP;
               end
            end else if (lp) begin
               tick_nx = '0;
               mode_nx = MODE_EDIT_COUNT;
            end
         end
         MODE_COUNTDOWN: begin
            if (both) begin
               led_nx  = '0;
               mode_nx = MODE_IDLE;
               ev      = EV_RESET;
            end else if (tick_inc >= total_ff) begin
               tick_nx = '0;
               mode_nx = MODE_ALERT;
               ev      = EV_EXPIRED;
            end else if (phase_step == '0) begin
               shade    = fade_shade;
               level_nx = level_dec;
               if (level_dec == '0) begin
                  led_nx   = led_ff - 1'b1;
                  level_nx = LEVEL_TOP;
               end
               ev = EV_FADE;
            end
         end
         MODE_ALERT: begin
            if (both) begin
               led_nx  = '0;
               mode_nx = MODE_IDLE;
               ev      = EV_RESET;
            end else if (st) begin
               tick_nx  = '0;
               phase_nx = '0;
               level_nx = LEVEL_TOP;
               led_nx   = '0;
               mode_nx  = MODE_COUNTUP;
            end else if (tick_inc >= TICK_W'(flash_ticks_ff)) begin
               flash_nx = !flash_ff;
               tick_nx  = '0;
               shade    = alert_ff;
               ev       = EV_FLASH;
            end
         end
         MODE_COUNTUP: begin
            if (st) begin
               led_nx  = '0;
               mode_nx = MODE_IDLE;
               ev      = EV_RESET;
            end else if (tick_inc >= total_ff) begin
               led_nx  = '0;
               mode_nx = MODE_IDLE;
               ev      = EV_EXPIRED;
            end else if (phase_step == '0) begin
               shade    = fade_shade;
               level_nx = level_dec;
               if (level_dec == '0) begin
                  led_nx   = led_ff + 1'b1;
                  level_nx = LEVEL_TOP;
               end
               ev = EV_FADE;
            end
         end
         MODE_EDIT_COUNT: begin
            if (both) begin
               tick_nx = '0;
               mode_nx = MODE_EDIT_ALERT;
            end else if (tick_inc >= TICK_W'(timeout_ff)) begin
               saved_nx = count_ff;
               led_nx   = '0;
               mode_nx  = MODE_IDLE;
               ev       = EV_SAVED;
            end else if (ad || st) begin
               tick_nx  = '0;
               count_nx = bright_step(count_ff, ad);
               shade    = count_nx;
               ev       = EV_BRIGHT;
            end
         end
         MODE_EDIT_ALERT: begin
            if (tick_inc >= TICK_W'(timeout_ff) || both) begin
               saved_nx = count_ff;
               led_nx   = '0;
               mode_nx  = MODE_IDLE;
               ev       = EV_SAVED;
            end else if (ad || st) begin
               tick_nx  = '0;
               alert_nx = bright_step(alert_ff, ad);
               shade    = alert_nx;
               ev       = EV_BRIGHT;
            end
         end
         default: begin
            led_nx  = '0;
            mode_nx = MODE_IDLE;
         end
      endcase
   end

   assign scale_nx = SCALE_W'(run_leds) * SCALE_W'(FADE_LEVELS);

   assign active = (mode_nx == MODE_IDLE || mode_nx == MODE_COUNTDOWN ||
                    mode_nx == MODE_COUNTUP) ? led_nx : '0;
   assign full   = (mode_nx == MODE_ALERT || mode_nx == MODE_EDIT_ALERT) ? alert_nx : count_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpl_ff         <= TICKS_PER_LEVEL_RESET;
         flash_ticks_ff <= FLASH_TICKS_RESET;
         timeout_ff     <= TIMEOUT_TICKS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TICKS_PER_LEVEL: tpl_ff         <= csr_data;
            CSR_FLASH_TICKS:     flash_ticks_ff <= csr_data;
            CSR_TIMEOUT_TICKS:   timeout_ff     <= csr_data;
            default: begin
               tpl_ff <= tpl_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         btn_start_ff  <= req_btn_start;
         btn_add_ff    <= req_btn_add;
         long_press_ff <= req_long_press_add;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         led_ff   <= '0;
         level_ff <= '0;
         tick_ff  <= '0;
         total_ff <= '0;
         phase_ff <= '0;
         flash_ff <= 1'b0;
         count_ff <= COUNT_BRIGHT_RESET;
         alert_ff <= ALERT_BRIGHT_RESET;
         saved_ff <= COUNT_BRIGHT_RESET;
         unit_ff  <= UNIT_RESET;
      end else if (cmd.exec) begin
         mode_ff  <= mode_nx;
         led_ff   <= led_nx;
         level_ff <= level_nx;
         tick_ff  <= tick_nx;
         phase_ff <= phase_nx;
         flash_ff <= flash_nx;
         count_ff <= count_nx;
         alert_ff <= alert_nx;
         saved_ff <= saved_nx;
         unit_ff  <= BRIGHT_W'(saved_nx / FADE_LEVELS);
      end else if (cmd.scale) begin
         total_ff <= TICK_W'(scale_ff) * TICK_W'(period);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         scale_ff        <= scale_nx;
         rsp_timer_mode  <= mode_nx;
         rsp_active_led  <= active;
         rsp_shade_value <= shade;
         rsp_full_value  <= full;
         rsp_flash_phase <= flash_nx;
         rsp_event_code  <= ev;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/led_ring_visual_timer_fsm.sv =====
// ----------------------------------------------------------------------------
// LED ring visual timer
// Six-mode ring timer advanced by one button tick per request: LED setup,
// countdown, alert flashing, count-up and two brightness edit modes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  req      in         req_valid/req_ready    btn_start, btn_add, long_press_add
//  rsp      out        rsp_valid/rsp_ready    mode, LED, shade, full, phase, event
//  csr      in         csr_valid/csr_ready    csr_index, csr_data (24 bit)
//
//  A request is captured, then executed; a request that starts a countdown or
//  count-up also passes a scale state, to form the run length by one 8 x 24 bit multiply.
//  A new request is taken while the previous response waits; the state update
//  of that request waits until the response register is free.
//  Reset is synchronous; settings and timer state take their reset values at
//  once, with no clearing pass. The settings port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module led_ring_visual_timer_fsm
   import lrvt_pkg::*;
#(
   parameter int NUM_RING_LEDS = NUM_RING_LEDS_DEFAULT,
   parameter int FADE_LEVELS   = FADE_LEVELS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_btn_start,
   input  wire logic                 req_btn_add,
   input  wire logic                 req_long_press_add,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0]                rsp_timer_mode,
   output logic [LED_W-1:0]          rsp_active_led,
   output logic [BRIGHT_W-1:0]       rsp_shade_value,
   output logic [BRIGHT_W-1:0]       rsp_full_value,
   output logic                      rsp_flash_phase,
   output logic [2:0]                rsp_event_code,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   lrvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrvt_datapath #(
      .NUM_RING_LEDS (NUM_RING_LEDS),
      .FADE_LEVELS   (FADE_LEVELS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_btn_start      (req_btn_start),
      .req_btn_add        (req_btn_add),
      .req_long_press_add (req_long_press_add),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_timer_mode     (rsp_timer_mode),
      .rsp_active_led     (rsp_active_led),
      .rsp_shade_value    (rsp_shade_value),
      .rsp_full_value     (rsp_full_value),
      .rsp_flash_phase    (rsp_flash_phase),
      .rsp_event_code     (rsp_event_code)
   );

endmodule

`default_nettype wire

// ===== verif/led_ring_visual_timer_fsm_test.sv =====
// ----------------------------------------------------------------------------
// LED ring visual timer testbench
// Drives button ticks into the ring timer through its request channel, keeps
// a cycle-free model of the six timer modes, and checks every response field
// against it. Settings are reprogrammed between stimulus segments while the
// block is drained, and the two channels idle at random in three of four phases.
// ----------------------------------------------------------------------------
`default_nettype none

module led_ring_visual_timer_fsm_test;
   import lrvt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_LEDS   = NUM_RING_LEDS_DEFAULT;
   localparam int FADE        = FADE_LEVELS_DEFAULT;
   localparam int ITEM_TARGET = 1800;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic start;
      logic add;
      logic long_press;
   } buttons_t;

   typedef struct packed {
      mode_type             mode;
      logic [LED_W-1:0]     led;
      logic [BRIGHT_W-1:0]  shade;
      logic [BRIGHT_W-1:0]  full;
      logic                 phase;
      event_type            ev;
   } timer_view_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_btn_start = 1'b0;
   logic                 req_btn_add = 1'b0;
   logic                 req_long_press_add = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [2:0]           rsp_timer_mode;
   logic [LED_W-1:0]     rsp_active_led;
   logic [BRIGHT_W-1:0]  rsp_shade_value;
   logic [BRIGHT_W-1:0]  rsp_full_value;
   logic                 rsp_flash_phase;
   logic [2:0]           rsp_event_code;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;

   led_ring_visual_timer_fsm DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_btn_start      (req_btn_start),
      .req_btn_add        (req_btn_add),
      .req_long_press_add (req_long_press_add),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_timer_mode     (rsp_timer_mode),
      .rsp_active_led     (rsp_active_led),
      .rsp_shade_value    (rsp_shade_value),
      .rsp_full_value     (rsp_full_value),
      .rsp_flash_phase    (rsp_flash_phase),
      .rsp_event_code     (rsp_event_code),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   buttons_t    button_queue[$];
   timer_view_t expected_views[$];
   buttons_t    held_item;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          fault_count = 0;
   int          items_made = 0;
   int          cycle_count = 0;

   logic [CFG_W-1:0]    ticks_per_level_cfg = TICKS_PER_LEVEL_RESET;
   logic [CFG_W-1:0]    flash_ticks_cfg = FLASH_TICKS_RESET;
   logic [CFG_W-1:0]    timeout_cfg = TIMEOUT_TICKS_RESET;
   mode_type            cur_mode = MODE_IDLE;
   logic [LED_W-1:0]    led_index = '0;
   logic [LEVEL_W-1:0]  fade_level = '0;
   logic [31:0]         elapsed = '0;
   logic [31:0]         run_length = '0;
   logic                flash_on = 1'b0;
   logic [BRIGHT_W-1:0] count_bright = COUNT_BRIGHT_RESET;
   logic [BRIGHT_W-1:0] alert_bright = ALERT_BRIGHT_RESET;
   logic [BRIGHT_W-1:0] saved_bright = COUNT_BRIGHT_RESET;

   function automatic logic [31:0] level_period();
      return (ticks_per_level_cfg == '0) ? 32'd1 : {8'd0, ticks_per_level_cfg};
   endfunction

   function automatic logic [BRIGHT_W-1:0] level_shade(input logic [LEVEL_W-1:0] lvl);
      logic [31:0] v;
      v = lvl * (saved_bright / FADE);
      return v[BRIGHT_W-1:0];
   endfunction

   function automatic logic [BRIGHT_W-1:0] adjust_bright(input logic [BRIGHT_W-1:0] b,
                                                         input logic up);
      int v;
      if (up) begin
         v = b + BRIGHT_STEP;
         return (v > BRIGHT_MAX) ? BRIGHT_MAX : BRIGHT_W'(v);
      end
      return (b >= BRIGHT_STEP) ? b - BRIGHT_STEP : '0;
   endfunction

   task automatic launch_run(input int unsigned leds, input mode_type m);
      logic [63:0] product;
      product = 64'(leds) * 64'(level_period()) * 64'(FADE);
      run_length = product[31:0];
      elapsed = '0;
      fade_level = LEVEL_W'(FADE);
      cur_mode = m;
   endtask

   task automatic return_to_idle();
      led_index = '0;
      cur_mode = MODE_IDLE;
   endtask

   task automatic predict_tick(input buttons_t b);
      logic st;
      logic ad;
      logic lp;
      event_type ev;
      logic [BRIGHT_W-1:0] shade;
      logic [31:0] period;
      timer_view_t v;
      st = b.start;
      ad = b.add;
      lp = b.long_press;
      ev = EV_NONE;
      shade = '0;
      period = level_period();
      if (cur_mode != MODE_IDLE && elapsed != '1) elapsed = elapsed + 1;
      case (cur_mode)
         MODE_IDLE: begin
            if (st && ad) begin
               return_to_idle();
               ev = EV_RESET;
            end else if (ad) begin
               if (led_index < RING_LEDS) begin
                  led_index = led_index + 1'b1;
                  ev = EV_ADDED;
               end else begin
                  return_to_idle();
                  ev = EV_RESET;
               end
            end else if (st) begin
               if (led_index > 0) begin
                  launch_run(led_index, MODE_COUNTDOWN);
                  led_index = led_index - 1'b1;
               end else begin
                  launch_run(RING_LEDS, MODE_COUNTUP);
                  led_index = '0;
               end
            end else if (lp) begin
               elapsed = '0;
               cur_mode = MODE_EDIT_COUNT;
            end
         end
         MODE_COUNTDOWN: begin
            if (st && ad) begin
               return_to_idle();
               ev = EV_RESET;
            end else if (elapsed >= run_length) begin
               elapsed = '0;
               cur_mode = MODE_ALERT;
               ev = EV_EXPIRED;
            end else if (elapsed % period == 0) begin
               fade_level = fade_level - 1'b1;
               shade = level_shade(fade_level);
               if (fade_level == 0) begin
                  led_index = led_index - 1'b1;
                  fade_level = LEVEL_W'(FADE);
               end
               ev = EV_FADE;
            end
         end
         MODE_ALERT: begin
            if (st && ad) begin
               return_to_idle();
               ev = EV_RESET;
            end else if (st) begin
               launch_run(RING_LEDS, MODE_COUNTUP);
               led_index = '0;
            end else if (elapsed >= {8'd0, flash_ticks_cfg}) begin
               flash_on = ~flash_on;
               elapsed = '0;
               shade = alert_bright;
               ev = EV_FLASH;
            end
         end
         MODE_COUNTUP: begin
            if (st) begin
               return_to_idle();
               ev = EV_RESET;
            end else if (elapsed >= run_length) begin
               return_to_idle();
               ev = EV_EXPIRED;
            end else if (elapsed % period == 0) begin
               fade_level = fade_level - 1'b1;
               shade = level_shade(LEVEL_W'(FADE) - fade_level);
               if (fade_level == 0) begin
                  led_index = led_index + 1'b1;
                  fade_level = LEVEL_W'(FADE);
               end
               ev = EV_FADE;
            end
         end
         MODE_EDIT_COUNT: begin
            if (st && ad) begin
               elapsed = '0;
               cur_mode = MODE_EDIT_ALERT;
            end else if (elapsed >= {8'd0, timeout_cfg}) begin
               saved_bright = count_bright;
               return_to_idle();
               ev = EV_SAVED;
            end else if (ad || st) begin
               elapsed = '0;
               count_bright = adjust_bright(count_bright, ad);
               shade = count_bright;
               ev = EV_BRIGHT;
            end
         end
         MODE_EDIT_ALERT: begin
            if (elapsed >= {8'd0, timeout_cfg} || (st && ad)) begin
               saved_bright = count_bright;
               return_to_idle();
               ev = EV_SAVED;
            end else if (ad || st) begin
               elapsed = '0;
               alert_bright = adjust_bright(alert_bright, ad);
               shade = alert_bright;
               ev = EV_BRIGHT;
            end
         end
         default: begin
            return_to_idle();
         end
      endcase
      v.mode = cur_mode;
      v.led = (cur_mode == MODE_IDLE || cur_mode == MODE_COUNTDOWN ||
               cur_mode == MODE_COUNTUP) ? led_index : '0;
      v.shade = shade;
      v.full = (cur_mode == MODE_ALERT || cur_mode == MODE_EDIT_ALERT) ?
               alert_bright : count_bright;
      v.phase = flash_on;
      v.ev = ev;
      expected_views.push_back(v);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) predict_tick(held_item);
         if (button_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            held_item = button_queue.pop_front();
            req_valid <= 1'b1;
            req_btn_start <= held_item.start;
            req_btn_add <= held_item.add;
            req_long_press_add <= held_item.long_press;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      timer_view_t got;
      timer_view_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = timer_view_t'({rsp_timer_mode, rsp_active_led, rsp_shade_value,
                                 rsp_full_value, rsp_flash_phase, rsp_event_code});
            if (expected_views.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("Response with no request waiting: mode %0d event %0d",
                           got.mode, got.ev);
            end else begin
               want = expected_views.pop_front();
               if (got !== want) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display({"Mismatch (expected/actual): mode %0d/%0d led %0d/%0d ",
                               "shade %0d/%0d full %0d/%0d phase %0d/%0d event %0d/%0d"},
                              want.mode, got.mode, want.led, got.led, want.shade,
                              got.shade, want.full, got.full, want.phase, got.phase,
                              want.ev, got.ev);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_buttons(input logic st, input logic ad, input logic lp);
      buttons_t b;
      b.start = st;
      b.add = ad;
      b.long_press = lp;
      button_queue.push_back(b);
      items_made++;
   endtask

   task automatic push_noise();
      logic [2:0] r;
      r = 3'($urandom_range(7));
      if (r[2] && r[1] && $urandom_range(3) != 0) r[2] = 1'b0;
      push_buttons(r[2], r[1], r[0]);
   endtask

   task automatic push_quiet(input int n);
      repeat (n) begin
         if ($urandom_range(99) < 4) push_noise();
         else push_buttons(1'b0, 1'b0, 1'b0);
      end
   endtask

   task automatic settle();
      while (button_queue.size() != 0 || req_valid || expected_views.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_setting(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TICKS_PER_LEVEL: ticks_per_level_cfg = value;
         CSR_FLASH_TICKS:     flash_ticks_cfg = value;
         CSR_TIMEOUT_TICKS:   timeout_cfg = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CFG_W-1:0] pick_setting(input logic [CSR_IDX_W-1:0] idx);
      int r;
      r = $urandom_range(99);
      if (r < 3) return '1;
      if (r < 12) return '0;
      case (idx)
         CSR_TICKS_PER_LEVEL:
            return (r < 90) ? CFG_W'($urandom_range(4, 1)) : CFG_W'($urandom_range(16, 5));
         CSR_FLASH_TICKS: return CFG_W'($urandom_range(6, 1));
         default: return CFG_W'($urandom_range(15, 1));
      endcase
   endfunction

   task automatic edit_session();
      int steps;
      logic up;
      logic dir;
      steps = ($urandom_range(3) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
      up = 1'($urandom_range(1));
      repeat (steps) begin
         dir = ($urandom_range(4) == 0) ? ~up : up;
         push_buttons(~dir, dir, 1'b0);
         push_quiet($urandom_range(2));
      end
      case ($urandom_range(3))
         0: push_buttons(1'b1, 1'b1, 1'b0);
         1: push_quiet($urandom_range(20));
         default: ;
      endcase
   endtask

   task automatic make_segment();
      int r;
      int n;
      case (cur_mode)
         MODE_IDLE: begin
            r = $urandom_range(9);
            if (r <= 4) begin
               if ($urandom_range(9) == 0) n = RING_LEDS + 1 - led_index + $urandom_range(3);
               else n = $urandom_range(RING_LEDS - led_index);
               repeat (n) push_buttons(1'b0, 1'b1, 1'b0);
               push_buttons(1'b1, 1'b0, 1'b0);
               push_quiet($urandom_range(150, 20));
            end else if (r <= 6) begin
               if (led_index != 0) push_buttons(1'b1, 1'b1, 1'b0);
               push_buttons(1'b1, 1'b0, 1'b0);
               push_quiet($urandom_range(150, 20));
            end else if (r <= 8) begin
               push_buttons(1'b0, 1'b0, 1'b1);
               edit_session();
            end else begin
               repeat ($urandom_range(6, 1)) push_noise();
            end
         end
         MODE_COUNTDOWN, MODE_COUNTUP: begin
            if ($urandom_range(4) == 0)
               push_buttons(1'b1, cur_mode == MODE_COUNTDOWN, 1'b0);
            else
               push_quiet($urandom_range(150, 10));
         end
         MODE_ALERT: begin
            push_quiet($urandom_range(20));
            case ($urandom_range(3))
               0, 1: push_buttons(1'b1, 1'b0, 1'b0);
               2: push_buttons(1'b1, 1'b1, 1'b0);
               default: ;
            endcase
         end
         MODE_EDIT_COUNT, MODE_EDIT_ALERT: edit_session();
         default: push_noise();
      endcase
   endtask

   initial begin
      int phase;
      logic [CSR_IDX_W-1:0] idx;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: brightness edits, LED setup and a short count-up.
      push_buttons(1'b0, 1'b0, 1'b1);
      push_buttons(1'b1, 1'b0, 1'b0);
      push_buttons(1'b0, 1'b1, 1'b0);
      push_buttons(1'b0, 1'b1, 1'b0);
      push_buttons(1'b1, 1'b1, 1'b0);
      push_buttons(1'b0, 1'b1, 1'b0);
      push_buttons(1'b1, 1'b1, 1'b0);
      push_buttons(1'b0, 1'b1, 1'b0);
      push_buttons(1'b0, 1'b1, 1'b0);
      push_buttons(1'b1, 1'b1, 1'b0);
      push_buttons(1'b1, 1'b0, 1'b0);
      push_buttons(1'b0, 1'b0, 1'b1);
      push_buttons(1'b1, 1'b0, 1'b0);
      settle();

      // A zero level period acts as one: a full one-LED countdown into the alert.
      write_setting(CSR_TICKS_PER_LEVEL, '0);
      write_setting(CSR_FLASH_TICKS, CFG_W'(1));
      write_setting(CSR_TIMEOUT_TICKS, CFG_W'(2));
      push_buttons(1'b0, 1'b1, 1'b0);
      push_buttons(1'b1, 1'b0, 1'b0);
      repeat (9) push_buttons(1'b0, 1'b0, 1'b0);
      push_buttons(1'b1, 1'b0, 1'b0);
      push_buttons(1'b1, 1'b0, 1'b0);
      push_buttons(1'b0, 1'b0, 1'b1);
      repeat (3) push_buttons(1'b0, 1'b0, 1'b0);
      settle();

      write_setting(CSR_TICKS_PER_LEVEL, '1);
      write_setting(CSR_FLASH_TICKS, '1);
      write_setting(CSR_TIMEOUT_TICKS, '1);
      push_buttons(1'b1, 1'b0, 1'b0);
      repeat (3) push_buttons(1'b0, 1'b0, 1'b0);
      push_buttons(1'b1, 1'b0, 1'b0);
      push_buttons(1'b0, 1'b0, 1'b1);
      repeat (2) push_buttons(1'b0, 1'b0, 1'b0);
      push_buttons(1'b1, 1'b1, 1'b0);
      push_buttons(1'b1, 1'b1, 1'b0);
      settle();

      write_setting(CSR_TICKS_PER_LEVEL, CFG_W'(1));
      write_setting(CSR_FLASH_TICKS, '0);
      write_setting(CSR_TIMEOUT_TICKS, '0);
      push_buttons(1'b0, 1'b1, 1'b0);
      push_buttons(1'b1, 1'b0, 1'b0);
      repeat (10) push_buttons(1'b0, 1'b0, 1'b0);
      push_buttons(1'b1, 1'b1, 1'b0);
      push_buttons(1'b0, 1'b0, 1'b1);
      push_buttons(1'b0, 1'b0, 1'b0);
      settle();

      write_setting(CSR_TICKS_PER_LEVEL, CFG_W'(2));
      write_setting(CSR_FLASH_TICKS, CFG_W'(3));
      write_setting(CSR_TIMEOUT_TICKS, CFG_W'(8));
      items_made = 0;
      while (items_made < ITEM_TARGET) begin
         phase = items_made * 4 / ITEM_TARGET;
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(2))
               0: idx = CSR_TICKS_PER_LEVEL;
               1: idx = CSR_FLASH_TICKS;
               default: idx = CSR_TIMEOUT_TICKS;
            endcase
            write_setting(idx, pick_setting(idx));
         end
         make_segment();
         settle();
      end
      repeat (20) @(posedge clock);
      if (fault_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/lrvt_pkg.sv
rtl/lrvt_ctrl.sv
rtl/lrvt_datapath.sv
rtl/led_ring_visual_timer_fsm.sv
verif/led_ring_visual_timer_fsm_test.sv
